>>> hdl/csim_pkg.sv
// Shared types and constants for the cosine similarity block.
package csim_pkg;

    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int DOT_W      = 42;
    localparam int SQ_W       = 41;
    localparam int HALF_W     = 21;
    localparam int MUL_W      = 2 * DOT_W;
    localparam int PXY_W      = 2 * SQ_W;
    localparam int DIV_STEPS  = 30;
    localparam int SQRT_STEPS = 15;
    localparam int CNT_W      = 5;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;
    localparam int LVL_W      = 2;
    localparam int SIM_W      = 16;

    localparam logic [SIM_W-1:0] SIM_MAX = 16'h7FFF;
    localparam logic [SIM_W-1:0] Q_ONE   = 16'h8000;

    typedef struct packed {
        logic [DOT_W-1:0] dot;
        logic [SQ_W-1:0]  xsq;
        logic [SQ_W-1:0]  ysq;
    } t_sums;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_back_state;

endpackage

>>> hdl/csim_front.sv
// Front part: per-pair products and the three running sums, handed on at the last pair.
module csim_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [csim_pkg::ELEM_W-1:0] i_x_elem,
    input  logic signed [csim_pkg::ELEM_W-1:0] i_y_elem,
    input  logic                          i_last,
    input  logic [csim_pkg::LVL_W-1:0]    i_q_level,
    output logic                          o_q_push,
    output csim_pkg::t_sums               o_q_data
);
    import csim_pkg::*;

    logic                     w_accept;
    logic signed [PROD_W-1:0] w_pxy;
    logic signed [PROD_W-1:0] w_pxx;
    logic signed [PROD_W-1:0] w_pyy;
    logic [LVL_W:0]           w_inflight;

    logic                     r_a_valid;
    logic                     r_a_last;
    logic signed [PROD_W-1:0] r_pxy;
    logic [PROD_W-2:0]        r_pxx;
    logic [PROD_W-2:0]        r_pyy;

    logic [DOT_W-1:0]         r_dot;
    logic [SQ_W-1:0]          r_xsq;
    logic [SQ_W-1:0]          r_ysq;
    logic [DOT_W-1:0]         w_dot;
    logic [SQ_W-1:0]          w_xsq;
    logic [SQ_W-1:0]          w_ysq;

    // A last item is taken only when the queue is sure to have room for its sums.
    assign w_inflight = {1'b0, i_q_level} + {{LVL_W{1'b0}}, (r_a_valid & r_a_last)};
    assign o_in_stall = (w_inflight >= (LVL_W+1)'(FIFO_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_pxy = PROD_W'(i_x_elem) * PROD_W'(i_y_elem);
    assign w_pxx = PROD_W'(i_x_elem) * PROD_W'(i_x_elem);
    assign w_pyy = PROD_W'(i_y_elem) * PROD_W'(i_y_elem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_last <= i_last;
            r_pxy    <= w_pxy;
            r_pxx    <= w_pxx[PROD_W-2:0];
            r_pyy    <= w_pyy[PROD_W-2:0];
        end
    end

    assign w_dot = r_dot + {{(DOT_W-PROD_W){r_pxy[PROD_W-1]}}, r_pxy};
    assign w_xsq = r_xsq + {{(SQ_W-PROD_W+1){1'b0}}, r_pxx};
    assign w_ysq = r_ysq + {{(SQ_W-PROD_W+1){1'b0}}, r_pyy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_xsq <= '0;
            r_ysq <= '0;
        end else if (r_a_valid) begin
            if (r_a_last) begin
                r_dot <= '0;
                r_xsq <= '0;
                r_ysq <= '0;
            end else begin
                r_dot <= w_dot;
                r_xsq <= w_xsq;
                r_ysq <= w_ysq;
            end
        end
    end

    assign o_q_push     = r_a_valid && r_a_last;
    assign o_q_data.dot = w_dot;
    assign o_q_data.xsq = w_xsq;
    assign o_q_data.ysq = w_ysq;

endmodule

>>> hdl/csim_fifo.sv
// Short queue of finished sums between the front and back parts.
module csim_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  csim_pkg::t_sums            i_data,
    input  logic                       i_pop,
    output csim_pkg::t_sums            o_data,
    output logic [csim_pkg::LVL_W-1:0] o_level,
    output logic                       o_empty
);
    import csim_pkg::*;

    t_sums              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [LVL_W-1:0]   r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (!i_push && i_pop) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;
    assign o_empty = (r_level == '0);

endmodule

>>> hdl/csim_back.sv
// Back part: squares, ratio test, restoring division and integer square root per vector.
module csim_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  csim_pkg::t_sums            i_q_data,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [csim_pkg::SIM_W-1:0] o_similarity,
    output logic                       o_zero_norm
);
    import csim_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [DOT_W-1:0]  r_mag;
    logic [SQ_W-1:0]   r_xsq;
    logic [SQ_W-1:0]   r_ysq;
    logic              r_neg;
    logic              r_zero;
    logic              r_phase;
    logic [2:0]        r_k;
    logic [1:0]        r_sh;
    logic [DOT_W-1:0]  r_pp;
    logic [MUL_W-1:0]  r_acc;
    logic [MUL_W-1:0]  r_m2;
    logic [PXY_W-1:0]  r_p;
    logic [PXY_W-1:0]  r_rem;
    logic [DIV_STEPS-1:0] r_d;
    logic [SQRT_STEPS-1:0] r_root;
    logic [SQRT_STEPS+1:0] r_srem;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIM_W-1:0]  r_q;
    logic              r_out_valid;
    logic [SIM_W-1:0]  r_sim;
    logic              r_zflag;

    logic [DOT_W-1:0]  w_mag;
    logic              w_zero;
    logic [DOT_W-1:0]  w_a;
    logic [DOT_W-1:0]  w_b;
    logic [HALF_W-1:0] w_a_h;
    logic [HALF_W-1:0] w_b_h;
    logic [MUL_W-1:0]  w_pp_sh;
    logic [MUL_W-1:0]  w_acc_nx;
    logic              w_sat;
    logic [PXY_W:0]    w_t;
    logic              w_div_ge;
    logic [SQRT_STEPS+3:0] w_sr;
    logic [SQRT_STEPS+3:0] w_trial;
    logic              w_sq_ge;
    logic              w_load;
    logic [SIM_W-1:0]  w_sim;

    assign w_mag  = i_q_data.dot[DOT_W-1] ? (~i_q_data.dot + DOT_W'(1)) : i_q_data.dot;
    assign w_zero = (i_q_data.xsq == '0) || (i_q_data.ysq == '0);

    // Each 42 by 42 product is built from four 21 by 21 partial products.
    assign w_a   = r_phase ? {1'b0, r_xsq} : r_mag;
    assign w_b   = r_phase ? {1'b0, r_ysq} : r_mag;
    assign w_a_h = r_k[0] ? w_a[DOT_W-1:HALF_W] : w_a[HALF_W-1:0];
    assign w_b_h = r_k[1] ? w_b[DOT_W-1:HALF_W] : w_b[HALF_W-1:0];

    always_comb begin
        case (r_sh)
            2'd0:    w_pp_sh = {{DOT_W{1'b0}}, r_pp};
            2'd1:    w_pp_sh = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            default: w_pp_sh = {r_pp, {DOT_W{1'b0}}};
        endcase
    end
    assign w_acc_nx = r_acc + w_pp_sh;

    // The quotient reaches one exactly when the squared dot product covers both norms.
    assign w_sat = (r_m2 >= {{(MUL_W-PXY_W){1'b0}}, r_p});

    assign w_t      = {r_rem, 1'b0};
    assign w_div_ge = (w_t >= {1'b0, r_p});

    assign w_sr    = {r_srem, r_d[DIV_STEPS-1:DIV_STEPS-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_sq_ge = (w_sr >= w_trial);

    assign w_load = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_zero) begin
            w_sim = '0;
        end else if (r_neg) begin
            w_sim = ~r_q + SIM_W'(1);
        end else if (r_q > SIM_MAX) begin
            w_sim = SIM_MAX;
        end else begin
            w_sim = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = w_zero ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                if ((r_k == 3'd4) && r_phase) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = w_sat ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    r_mag   <= w_mag;
                    r_xsq   <= i_q_data.xsq;
                    r_ysq   <= i_q_data.ysq;
                    r_neg   <= i_q_data.dot[DOT_W-1];
                    r_zero  <= w_zero;
                    r_phase <= 1'b0;
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_q     <= '0;
                end
            end
            ST_MUL: begin
                if (r_k != 3'd4) begin
                    r_pp <= {{HALF_W{1'b0}}, w_a_h} * {{HALF_W{1'b0}}, w_b_h};
                    r_sh <= {1'b0, r_k[0]} + {1'b0, r_k[1]};
                end
                if (r_k == 3'd4) begin
                    r_k   <= '0;
                    r_acc <= '0;
                    if (!r_phase) begin
                        r_m2    <= w_acc_nx;
                        r_phase <= 1'b1;
                    end else begin
                        r_p <= w_acc_nx[PXY_W-1:0];
                    end
                end else begin
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) begin
                        r_acc <= w_acc_nx;
                    end
                end
            end
            ST_CMP: begin
                r_rem  <= r_m2[PXY_W-1:0];
                r_d    <= '0;
                r_cnt  <= '0;
                r_root <= '0;
                r_srem <= '0;
                if (w_sat) begin
                    r_q <= Q_ONE;
                end
            end
            ST_DIV: begin
                r_rem <= w_div_ge ? PXY_W'(w_t - {1'b0, r_p}) : w_t[PXY_W-1:0];
                r_d   <= {r_d[DIV_STEPS-2:0], w_div_ge};
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            ST_SQRT: begin
                r_srem <= w_sq_ge ? (SQRT_STEPS+2)'(w_sr - w_trial) : w_sr[SQRT_STEPS+1:0];
                r_root <= {r_root[SQRT_STEPS-2:0], w_sq_ge};
                r_d    <= {r_d[DIV_STEPS-3:0], 2'b00};
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    r_q <= {1'b0, r_root[SQRT_STEPS-2:0], w_sq_ge};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_load) begin
            r_sim   <= w_sim;
            r_zflag <= r_zero;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_similarity = r_sim;
    assign o_zero_norm  = r_zflag;

endmodule

>>> hdl/cosine_similarity_top.sv
// Top level of the streaming cosine similarity block.
//
// Input channel: one element pair (i_x_elem, i_y_elem) per item, with i_last on the
// final pair of a vector. Items are taken at one per cycle while o_in_stall is low.
// Output channel: one item per vector, o_similarity in signed Q1.15 (exactly 1.0
// saturates to 32767) and o_zero_norm, which is set with a zero result when either
// vector has zero magnitude.
// After the last pair, its products are registered and its sums pass through the queue;
// the back part takes them, forms the squared dot magnitude and the product of the two
// squared norms on its 21 by 21 multiplier, compares, runs 30 division steps and 15
// square root steps, and registers the result. A zero-norm vector skips the arithmetic,
// and a quotient of one skips the division and square root. Sums queue up two deep;
// pairs stream at one per cycle until the back engine, one vector at a time, falls behind.
// A stall on the output holds the result in its register; the engine finishes the
// next vector and waits, the queue fills, and then o_in_stall rises.
// Synchronous reset clears the sums, the queue and all valid flags; no result is
// pending after reset.
module cosine_similarity_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [csim_pkg::ELEM_W-1:0] i_x_elem,
    input  logic signed [csim_pkg::ELEM_W-1:0] i_y_elem,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [csim_pkg::SIM_W-1:0]  o_similarity,
    output logic                          o_zero_norm
);
    import csim_pkg::*;

    logic             w_push;
    t_sums            w_push_data;
    logic             w_pop;
    t_sums            w_pop_data;
    logic [LVL_W-1:0] w_level;
    logic             w_empty;

    csim_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_x_elem   (i_x_elem),
        .i_y_elem   (i_y_elem),
        .i_last     (i_last),
        .i_q_level  (w_level),
        .o_q_push   (w_push),
        .o_q_data   (w_push_data)
    );

    csim_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_level (w_level),
        .o_empty (w_empty)
    );

    csim_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_empty),
        .i_q_data     (w_pop_data),
        .o_q_pop      (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_similarity (o_similarity),
        .o_zero_norm  (o_zero_norm)
    );

endmodule

>>> hdl/csim_checker.sv
// Port-level checks for the cosine similarity block and the bind that attaches them.
module csim_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_stall,
    input logic                          o_out_valid,
    input logic signed [csim_pkg::SIM_W-1:0] o_similarity,
    input logic                          o_zero_norm
);
    import csim_pkg::*;

    // A result held back by the receiver stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_similarity) && $stable(o_zero_norm))
        else $error("output item changed while stalled");

    // A zero-magnitude vector always reports a zero similarity.
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_norm |-> o_similarity == '0)
        else $error("zero norm item with nonzero similarity");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind cosine_similarity_top csim_checker u_csim_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_stall  (i_out_stall),
    .o_out_valid  (o_out_valid),
    .o_similarity (o_similarity),
    .o_zero_norm  (o_zero_norm)
);
